// File: design/lcsl_pkg.sv
// Shared types and constants for the LRU cache set lookup.
// Used by lcsl_pick and lru_cache_set_lookup; depends on nothing.
package lcsl_pkg;

  localparam int WAYS      = 4;
  localparam int TAG_BITS  = 32;
  localparam int IN_BITS   = 32;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_BITS  = WAY_BITS;
  localparam int OUT_BITS  = 2;

  localparam logic [AGE_BITS-1:0] AGE_OLDEST = AGE_BITS'(WAYS - 1);

  typedef enum logic [OUT_BITS-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [WAY_BITS-1:0] way_t;

  typedef struct packed {
    outcome_t outcome;
    way_t     way;
    age_t     ref_age;
  } pick_t;

endpackage

// File: design/lcsl_pick.sv
// Way selection for one access: parallel tag compare, free-way search, victim search.
// Depends on lcsl_pkg.
module lcsl_pick (
  input  logic [lcsl_pkg::WAYS-1:0] way_valid,
  input  lcsl_pkg::tag_t            way_tag [lcsl_pkg::WAYS],
  input  lcsl_pkg::age_t            way_age [lcsl_pkg::WAYS],
  input  lcsl_pkg::tag_t            tag,
  output lcsl_pkg::pick_t           pick
);

  logic           hit;
  logic           have_free;
  lcsl_pkg::way_t hit_way;
  lcsl_pkg::way_t free_way;
  lcsl_pkg::way_t old_way;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    have_free = 1'b0;
    free_way  = '0;
    old_way   = '0;
    for (int i = lcsl_pkg::WAYS - 1; i >= 0; i--) begin
      if (way_valid[i] && way_tag[i] == tag) begin
        hit     = 1'b1;
        hit_way = lcsl_pkg::WAY_BITS'(i);
      end
      if (way_age[i] == lcsl_pkg::AGE_OLDEST) begin
        old_way = lcsl_pkg::WAY_BITS'(i);
      end
    end
    for (int i = 0; i < lcsl_pkg::WAYS; i++) begin
      if (!way_valid[i]) begin
        have_free = 1'b1;
        free_way  = lcsl_pkg::WAY_BITS'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      pick.outcome = lcsl_pkg::OUT_HIT;
      pick.way     = hit_way;
      pick.ref_age = way_age[hit_way];
    end else if (have_free) begin
      pick.outcome = lcsl_pkg::OUT_FILL;
      pick.way     = free_way;
      pick.ref_age = lcsl_pkg::AGE_OLDEST;
    end else begin
      pick.outcome = lcsl_pkg::OUT_EVICT;
      pick.way     = old_way;
      pick.ref_age = way_age[old_way];
    end
  end

endmodule

// File: design/lru_cache_set_lookup.sv
// Top level of one cache set with true LRU age counters.
// Depends on lcsl_pkg and lcsl_pick.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+----------------------
//  request  | in_valid  | in_stall  | access_tag
//  result   | out_valid | out_stall | outcome, way_used
//
// One request per cycle while in_stall is low; the result is registered as the request leaves the input register.
// A request sits in the input register, then tag compare, way pick and age update
// run combinationally as it moves into the result register.
// Reset clears all way valid bits and both registers' valid flags.
// A stalled result holds the input register; in_stall rises only when both are full.
module lru_cache_set_lookup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcsl_pkg::IN_BITS-1:0] access_tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcsl_pkg::OUT_BITS-1:0] outcome,
  output logic [1:0]                   way_used
);

  logic                      req_valid;
  lcsl_pkg::tag_t            req_tag;
  logic [lcsl_pkg::WAYS-1:0] way_valid;
  lcsl_pkg::tag_t            way_tag [lcsl_pkg::WAYS];
  lcsl_pkg::age_t            way_age [lcsl_pkg::WAYS];
  lcsl_pkg::pick_t           pick;
  lcsl_pkg::outcome_t        res_outcome;
  lcsl_pkg::way_t            res_way;
  logic                      advance;

  assign advance   = req_valid && (!out_valid || !out_stall);
  assign in_stall  = req_valid && !advance;
  assign outcome   = res_outcome;
  assign way_used  = res_way[1:0];

  lcsl_pick u_pick (
    .way_valid (way_valid),
    .way_tag   (way_tag),
    .way_age   (way_age),
    .tag       (req_tag),
    .pick      (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      req_tag <= access_tag[lcsl_pkg::TAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res_outcome <= pick.outcome;
      res_way     <= pick.way;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      way_valid <= '0;
    end else if (advance) begin
      way_valid[pick.way] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < lcsl_pkg::WAYS; i++) begin
        if (way_valid[i] && way_age[i] < pick.ref_age) begin
          way_age[i] <= way_age[i] + lcsl_pkg::AGE_BITS'(1);
        end
      end
      way_age[pick.way] <= '0;
      if (pick.outcome != lcsl_pkg::OUT_HIT) begin
        way_tag[pick.way] <= req_tag;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_free_way: assert property (@(posedge clk) disable iff (rst)
    advance && pick.outcome == lcsl_pkg::OUT_FILL |-> !way_valid[pick.way])
    else $error("fill picked a valid way");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    advance && pick.outcome == lcsl_pkg::OUT_EVICT |-> &way_valid)
    else $error("eviction with a free way");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && res_way == $past(pick.way))
    else $error("advanced request left no result");
`endif

endmodule
